// ----- design/wfba_pkg.sv -----
// Shared constants, codes and control types for the worst-fit block allocator.
package wfba_pkg;

  localparam int NUM_BLOCKS   = 16;
  localparam int SIZE_BITS    = 16;

  // Fixed port widths
  localparam int IN_IDX_BITS  = 4;
  localparam int IN_SIZE_BITS = 16;
  localparam int OUT_IDX_BITS = 4;
  localparam int CFG_BITS     = 5;

  // Derived widths
  localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);
  localparam int EXT_BITS = ((IDX_BITS > IN_IDX_BITS) ? IDX_BITS : IN_IDX_BITS) + 1;
  localparam int LIM_BITS = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;         // write one block's free size
    logic start_alloc;  // latch request, clear search state
    logic issue_rd;     // read next entry of the scan
    logic finish;       // commit allocation, emit result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic limit_zero;   // no block in the search range
    logic scan_last;    // current read is the last of the range
  } sts_t;

endpackage

// ----- design/wfba_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module wfba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/wfba_ctrl.sv -----
// Sequencing state machine: idle, scan, drain of the last read, finish.
module wfba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                opcode_i,
  input  wfba_pkg::sts_t      sts_i,
  output wfba_pkg::cmd_t      cmd_o,
  output logic                busy_o
);

  wfba_pkg::state_e state_q, state_d;
  wfba_pkg::opcode_e op;

  assign op = wfba_pkg::opcode_e'(opcode_i);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      wfba_pkg::ST_IDLE: begin
        if (start_i) begin
          if (op == wfba_pkg::OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start_alloc = 1'b1;
            state_d = sts_i.limit_zero ? wfba_pkg::ST_FINISH : wfba_pkg::ST_SCAN;
          end
        end
      end
      wfba_pkg::ST_SCAN: begin
        cmd_o.issue_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = wfba_pkg::ST_DRAIN;
        end
      end
      wfba_pkg::ST_DRAIN: begin
        state_d = wfba_pkg::ST_FINISH;
      end
      wfba_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = wfba_pkg::ST_IDLE;
      end
      default: begin
        state_d = wfba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wfba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != wfba_pkg::ST_IDLE);

endmodule

// ----- design/wfba_dp.sv -----
// Datapath: free-size table, scan counter, worst-fit compare and result registers.
module wfba_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wfba_pkg::CFG_BITS-1:0]      cfg_wdata_i,
  input  logic [wfba_pkg::IN_IDX_BITS-1:0]   block_index_i,
  input  logic [wfba_pkg::IN_SIZE_BITS-1:0]  size_value_i,
  input  wfba_pkg::cmd_t                     cmd_i,
  output wfba_pkg::sts_t                     sts_o,
  output logic                               done_o,
  output logic                               granted_o,
  output logic [wfba_pkg::OUT_IDX_BITS-1:0]  chosen_block_o
);

  logic [wfba_pkg::CFG_BITS-1:0]  count_q;
  logic [wfba_pkg::LIM_BITS-1:0]  count_ext;
  logic [wfba_pkg::CNT_BITS-1:0]  sat_limit;
  logic [wfba_pkg::CNT_BITS-1:0]  limit_q;
  logic [wfba_pkg::CNT_BITS-1:0]  scan_q;
  logic [wfba_pkg::CNT_BITS-1:0]  scan_nxt;
  logic [wfba_pkg::SIZE_BITS-1:0] size_in;
  logic [wfba_pkg::SIZE_BITS-1:0] req_q;
  logic [wfba_pkg::EXT_BITS-1:0]  load_idx_ext;
  logic                           load_ok;
  logic                           rd_pend_q;
  logic [wfba_pkg::IDX_BITS-1:0]  rd_idx_q;
  logic [wfba_pkg::SIZE_BITS-1:0] rd_data;
  logic                           found_q;
  logic [wfba_pkg::IDX_BITS-1:0]  best_idx_q;
  logic [wfba_pkg::SIZE_BITS-1:0] best_val_q;
  logic                           take;
  logic                           ram_we;
  logic [wfba_pkg::IDX_BITS-1:0]  ram_waddr;
  logic [wfba_pkg::SIZE_BITS-1:0] ram_wdata;
  logic                           done_q;
  logic                           granted_q;
  logic [wfba_pkg::OUT_IDX_BITS-1:0] chosen_q;

  // Block count saturates at the table depth
  assign count_ext = wfba_pkg::LIM_BITS'(count_q);
  assign sat_limit = (count_ext > wfba_pkg::LIM_BITS'(wfba_pkg::NUM_BLOCKS))
                   ? wfba_pkg::CNT_BITS'(wfba_pkg::NUM_BLOCKS)
                   : wfba_pkg::CNT_BITS'(count_ext);

  assign size_in      = wfba_pkg::SIZE_BITS'(size_value_i);
  assign load_idx_ext = wfba_pkg::EXT_BITS'(block_index_i);
  assign load_ok      = load_idx_ext < wfba_pkg::EXT_BITS'(wfba_pkg::NUM_BLOCKS);
  assign scan_nxt     = scan_q + wfba_pkg::CNT_BITS'(1);

  assign sts_o.limit_zero = (sat_limit == '0);
  assign sts_o.scan_last  = (scan_nxt == limit_q);

  // Strictly larger wins, so ties keep the lower index
  assign take = rd_pend_q && (rd_data >= req_q) && (!found_q || (rd_data > best_val_q));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wfba_pkg::IDX_BITS'(load_idx_ext);
    ram_wdata = size_in;
    if (cmd_i.load) begin
      ram_we = load_ok;
    end else if (cmd_i.finish) begin
      ram_we    = found_q;
      ram_waddr = best_idx_q;
      ram_wdata = best_val_q - req_q;
    end
  end

  wfba_ram #(
    .WIDTH(wfba_pkg::SIZE_BITS),
    .DEPTH(wfba_pkg::NUM_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_q[wfba_pkg::IDX_BITS-1:0]),
    .rdata_o (rd_data)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_pend_q <= 1'b0;
      found_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      rd_pend_q <= cmd_i.issue_rd;
      if (cmd_i.start_alloc) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
      done_q <= cmd_i.finish;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_alloc) begin
      req_q      <= size_in;
      limit_q    <= sat_limit;
      scan_q     <= '0;
      best_idx_q <= '0;
      best_val_q <= '0;
    end else begin
      if (cmd_i.issue_rd) begin
        scan_q <= scan_nxt;
      end
      if (take) begin
        best_idx_q <= rd_idx_q;
        best_val_q <= rd_data;
      end
    end
    rd_idx_q <= scan_q[wfba_pkg::IDX_BITS-1:0];
    if (cmd_i.finish) begin
      granted_q <= found_q;
      chosen_q  <= found_q ? wfba_pkg::OUT_IDX_BITS'(best_idx_q) : '0;
    end
  end

  assign done_o         = done_q;
  assign granted_o      = granted_q;
  assign chosen_block_o = chosen_q;

endmodule

// ----- design/worst_fit_block_allocator_core.sv -----
// Top level of the worst-fit block allocator.
//
// Keeps the free size of up to NUM_BLOCKS blocks in a small RAM. An item is
// taken when start_i is high and busy_o is low. A load item (opcode 0) writes
// size_value_i as the free size of block_index_i in the cycle it is taken,
// gives no result and leaves busy_o low, so another item may follow at once;
// a load to an index beyond the table is dropped. An allocate item (opcode 1)
// scans blocks 0 .. block_count-1 (count saturated at NUM_BLOCKS) one entry
// per cycle through the RAM's single read port, keeps the largest free size
// that fits the request (lowest index on ties), then subtracts the request
// from that block. When the count is 0 the scan is skipped.
// The result shows on granted_o / chosen_block_o for exactly one cycle with
// done_o high, in the cycle in which busy_o falls; the receiver cannot
// stall it, so it must take it then. chosen_block_o is 0 when nothing fits.
// block_count is written through cfg_we_i / cfg_wdata_i; the user must write it only while idle (not enforced).
// Every block in the search range must have been loaded before an allocate.
module worst_fit_block_allocator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration
  input  logic                               cfg_we_i,
  input  logic [wfba_pkg::CFG_BITS-1:0]      cfg_wdata_i,
  // Item in
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               opcode_i,
  input  logic [wfba_pkg::IN_IDX_BITS-1:0]   block_index_i,
  input  logic [wfba_pkg::IN_SIZE_BITS-1:0]  size_value_i,
  // Result out
  output logic                               done_o,
  output logic                               granted_o,
  output logic [wfba_pkg::OUT_IDX_BITS-1:0]  chosen_block_o
);

  wfba_pkg::cmd_t cmd;
  wfba_pkg::sts_t sts;

  // Controller acts on start_i only while idle, so a start_i it acts on means accepted.
  wfba_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  wfba_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .block_index_i  (block_index_i),
    .size_value_i   (size_value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .done_o         (done_o),
    .granted_o      (granted_o),
    .chosen_block_o (chosen_block_o)
  );

endmodule

// ----- design/wfba_checker.sv -----
// Port-level checks for the worst-fit block allocator, bound to the top level.
module wfba_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic                               opcode_i,
  input logic                               done_o,
  input logic                               granted_o,
  input logic [wfba_pkg::OUT_IDX_BITS-1:0]  chosen_block_o
);

  // Result is strobed only once the search is over
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o))
    else $error("result strobe without preceding busy period");

  a_nogrant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !granted_o) |-> (chosen_block_o == '0))
    else $error("chosen block not zero on a refused request");

  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (opcode_i == wfba_pkg::OP_ALLOC)) |=> busy_o)
    else $error("allocate item did not start a search");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (opcode_i == wfba_pkg::OP_LOAD)) |=> !busy_o && !done_o)
    else $error("load item caused busy or a result");

endmodule

bind worst_fit_block_allocator_core wfba_checker u_wfba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .opcode_i       (opcode_i),
  .done_o         (done_o),
  .granted_o      (granted_o),
  .chosen_block_o (chosen_block_o)
);
